### hdl/lzwe_pkg.sv
// shared constants for the lzw byte encoder
`default_nettype none
package lzwe_pkg;
  localparam int DictEntriesDefault = 4096;
  localparam int CodeBitsDefault = 12;
  localparam int ByteCodes = 256;
  localparam int CellCount = 16;
endpackage
`default_nettype wire

### hdl/lzwe_if.sv
// valid/ready stream interfaces for input bytes and output codes
`default_nettype none
interface lzwe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;
  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

interface lzwe_out_if #(parameter int CODE_BITS = 12);
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] code;
  logic                 final_code;
  modport source (output valid, code, final_code, input ready);
  modport sink (input valid, code, final_code, output ready);
endinterface
`default_nettype wire

### hdl/lzwe_cell.sv
// one search cell: a slice of the dictionary memory, scanned one address at a time
`default_nettype none
module lzwe_cell import lzwe_pkg::*; #(
  parameter int CODE_BITS = 12,
  parameter int SLICE = 240,
  parameter int CELL_ID = 0
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(SLICE)-1:0]     wr_addr,
  input  wire logic [CODE_BITS+7:0]         wr_data,
  input  wire logic [$clog2(SLICE)-1:0]     rd_addr,
  input  wire logic [CODE_BITS+7:0]         key,
  input  wire logic [CODE_BITS:0]           fill,
  input  wire logic                         hit_in,
  input  wire logic [CODE_BITS-1:0]         hit_code_in,
  output logic                              hit,
  output logic [CODE_BITS-1:0]              hit_code
);
  localparam int AW = $clog2(SLICE);
  logic [CODE_BITS+7:0] mem [SLICE];
  logic [CODE_BITS+7:0] rd_data;
  logic [AW-1:0]        rd_addr_q;
  logic                 match;
  logic [31:0]          idx;
  logic [CODE_BITS-1:0] my_code;

  // slice memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data   <= mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // entry index = address * cells + cell id, code = index + 256
  assign idx = 32'(rd_addr_q) * CellCount + CELL_ID;
  assign my_code = CODE_BITS'(idx + ByteCodes);
  // entries at or above the fill count are stale or unwritten
  assign match = (idx < 32'(fill)) && (rd_data == key);

  // hit chain: earlier cell wins; entries are unique so order is harmless
  always_comb begin
    hit = hit_in | match;
    hit_code = hit_in ? hit_code_in : my_code;
  end
endmodule
`default_nettype wire

### hdl/lzw_byte_encoder_core.sv
// top level: lzw encoder control and row of dictionary search cells
//
// channel | dir | payload
// in_s    | in  | data_byte, end_of_stream
// out_m   | out | code, final_code
//
// a byte is compared against 16 dictionary slices at once; each row of the
// slices is read in SCAN and compared in DRAIN, and rows are scanned in turn
// after a byte's transfer until the last used row or a row that hits.
// reset and end of stream empty the dictionary by clearing the fill count;
// entries at or above the fill count never match.
// up to two codes per byte are held in a result register; a stalled output
// holds the next byte until they are transferred.
`default_nettype none
module lzw_byte_encoder_core import lzwe_pkg::*; #(
  parameter int DICT_ENTRIES = DictEntriesDefault,
  parameter int CODE_BITS = CodeBitsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  lzwe_in_if.sink   in_s,
  lzwe_out_if.source out_m
);
  localparam int LIMIT = (DICT_ENTRIES < (1 << CODE_BITS)) ? DICT_ENTRIES : (1 << CODE_BITS);
  localparam int DEPTH = LIMIT - ByteCodes;
  localparam int SLICE = (DEPTH + CellCount - 1) / CellCount;
  localparam int AW = $clog2(SLICE);
  localparam int NW = CODE_BITS + 1;
  localparam int CW = $clog2(CellCount);

  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, EMIT} state_t;
  state_t state;

  logic [NW-1:0]        next_free;
  logic [CODE_BITS-1:0] cur;
  logic                 active;
  logic [7:0]           byte_q;
  logic                 last_q;
  logic [AW:0]          scan_addr;
  logic                 rd_live;
  logic [CODE_BITS-1:0] res_code [2];
  logic                 res_fin [2];
  logic [1:0]           res_cnt;
  logic                 res_idx;

  logic [NW-1:0]        used;
  logic [AW:0]          rows;
  logic                 hit_chain [CellCount+1];
  logic [CODE_BITS-1:0] code_chain [CellCount+1];
  logic [CODE_BITS+7:0] key;
  logic [NW-1:0]        widx;
  logic                 do_add;

  assign used = next_free - NW'(ByteCodes);
  assign rows = (AW+1)'((32'(used) + CellCount - 1) / CellCount);
  assign key = {cur, byte_q};
  assign widx = used;
  assign do_add = (state == EMIT) && active && !(rd_live && hit_chain[CellCount])
                  && (next_free < NW'(LIMIT));
  assign hit_chain[0] = 1'b0;
  assign code_chain[0] = '0;

  // row of search cells
  for (genvar g = 0; g < CellCount; g++) begin : g_cell
    lzwe_cell #(.CODE_BITS(CODE_BITS), .SLICE(SLICE), .CELL_ID(g)) u_cell (
      .clk(clk),
      .wr_en(do_add && (widx[CW-1:0] == CW'(g))),
      .wr_addr(AW'(widx >> CW)),
      .wr_data(key),
      .rd_addr(scan_addr[AW-1:0]),
      .key(key),
      .fill(used),
      .hit_in(hit_chain[g]),
      .hit_code_in(code_chain[g]),
      .hit(hit_chain[g+1]),
      .hit_code(code_chain[g+1])
    );
  end

  assign in_s.ready = (state == IDLE) && (res_cnt == 2'd0);
  assign out_m.valid = (res_cnt != 2'd0);
  assign out_m.code = res_code[res_idx];
  assign out_m.final_code = res_fin[res_idx];

  // control: scan rows, then resolve hit or miss; SCAN issues reads, EMIT sees last
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE; next_free <= NW'(ByteCodes); cur <= '0; active <= 1'b0;
      res_cnt <= 2'd0; res_idx <= 1'b0; scan_addr <= '0; rd_live <= 1'b0;
    end else begin
      if (out_m.valid && out_m.ready) begin
        if (res_cnt == 2'd2 && !res_idx) res_idx <= 1'b1;
        else begin res_cnt <= 2'd0; res_idx <= 1'b0; end
      end
      case (state)
        IDLE: begin
          if (in_s.valid && in_s.ready) begin
            byte_q <= in_s.data_byte; last_q <= in_s.end_of_stream;
            scan_addr <= '0;
            if (!active || rows == '0) begin
              rd_live <= 1'b0; state <= EMIT;
            end else begin
              rd_live <= 1'b1; state <= SCAN;
            end
          end
        end
        SCAN: begin
          // read for scan_addr issued; result visible next cycle
          state <= DRAIN;
        end
        DRAIN: begin
          if (hit_chain[CellCount] || scan_addr + 1'b1 >= rows) state <= EMIT;
          else begin scan_addr <= scan_addr + 1'b1; state <= SCAN; end
        end
        EMIT: begin
          if (!active) begin
            if (last_q) begin
              res_code[0] <= CODE_BITS'(byte_q); res_fin[0] <= 1'b1; res_cnt <= 2'd1;
            end else begin
              cur <= CODE_BITS'(byte_q); active <= 1'b1;
            end
          end else if (rd_live && hit_chain[CellCount]) begin
            if (last_q) begin
              res_code[0] <= code_chain[CellCount]; res_fin[0] <= 1'b1; res_cnt <= 2'd1;
            end else cur <= code_chain[CellCount];
          end else begin
            res_code[0] <= cur; res_fin[0] <= 1'b0;
            res_code[1] <= CODE_BITS'(byte_q); res_fin[1] <= 1'b1;
            res_cnt <= last_q ? 2'd2 : 2'd1;
            cur <= CODE_BITS'(byte_q);
            if (next_free < NW'(LIMIT)) next_free <= next_free + 1'b1;
          end
          if (last_q) begin
            active <= 1'b0; cur <= '0; next_free <= NW'(ByteCodes);
          end
          res_idx <= 1'b0;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### dv/lzw_byte_encoder_core_chk.sv
// checker: watches byte and code channels, predicts lzw codes and compares
`timescale 1ns / 1ps
module lzw_byte_encoder_core_chk #(
  parameter int DICT_ENTRIES = 4096,
  parameter int CODE_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic in_eos,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire logic [CODE_BITS-1:0] out_code,
  input  wire logic out_final,
  output int fail_count,
  output int codes_pending
);
  localparam int ByteCodes = 256;
  localparam int CodeLimit = (DICT_ENTRIES < (1 << CODE_BITS)) ? DICT_ENTRIES
                                                                : (1 << CODE_BITS);

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 fin;
  } code_word_t;

  // pair (prefix, byte) -> assigned code
  int unsigned pair_dict [int unsigned];
  int unsigned free_code;
  logic [CODE_BITS-1:0] cur_code;
  logic active;
  code_word_t code_fifo [$];

  assign codes_pending = code_fifo.size();

  task automatic clear_dict();
    pair_dict.delete();
    free_code = ByteCodes;
    cur_code = '0;
    active = 1'b0;
  endtask

  // one input byte through the encoder model
  task automatic encode_byte(input logic [7:0] b, input logic last);
    int unsigned key;
    code_word_t w;
    key = (32'(cur_code) << 8) | 32'(b);
    if (!active) begin
      cur_code = CODE_BITS'(b);
      active = 1'b1;
    end else if (pair_dict.exists(key)) begin
      cur_code = CODE_BITS'(pair_dict[key]);
    end else begin
      w.code = cur_code;
      w.fin = 1'b0;
      code_fifo.push_back(w);
      if (free_code < CodeLimit) begin
        pair_dict[key] = free_code;
        free_code++;
      end
      cur_code = CODE_BITS'(b);
    end
    if (last) begin
      w.code = cur_code;
      w.fin = 1'b1;
      code_fifo.push_back(w);
      clear_dict();
    end
  endtask

  initial begin
    fail_count = 0;
    clear_dict();
  end

  always @(posedge clk) begin
    code_word_t exp_w;
    if (rst) begin
      clear_dict();
      code_fifo.delete();
    end else begin
      // output transfer compared against oldest prediction
      if (out_valid && out_ready) begin
        if (code_fifo.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected code %0d final %0b", out_code, out_final);
        end else begin
          exp_w = code_fifo.pop_front();
          if (exp_w.code !== out_code || exp_w.fin !== out_final) begin
            fail_count++;
            if (fail_count <= 10)
              $display("code mismatch: exp %0d/%0b got %0d/%0b",
                       exp_w.code, exp_w.fin, out_code, out_final);
          end
        end
      end
      if (in_valid && in_ready) encode_byte(in_byte, in_eos);
    end
  end
endmodule

### dv/lzw_byte_encoder_core_tb.sv
// testbench top: byte stimulus, output stalls, watchdog and verdict
`timescale 1ns / 1ps
module lzw_byte_encoder_core_tb;
  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count;
  int codes_pending;
  int idle_cycles = 0;
  logic sink_busy = 1'b0;

  lzwe_in_if in_ch ();
  lzwe_out_if #(.CODE_BITS(12)) out_ch ();

  lzw_byte_encoder_core DUT (.clk(clk), .rst(rst), .in_s(in_ch.sink), .out_m(out_ch.source));

  lzw_byte_encoder_core_chk chk (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte(in_ch.data_byte), .in_eos(in_ch.end_of_stream),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_code(out_ch.code), .out_final(out_ch.final_code),
    .fail_count(fail_count), .codes_pending(codes_pending)
  );

  always #1 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 70) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one byte transfer, with a random gap first; called and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int g;
    logic took;
    g = sink_busy ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_stream <= last;
    // ready only moves at rising edges, so its value here decides the next edge
    do begin
      took = in_ch.ready;
      @(negedge clk);
    end while (!took);
  endtask

  // random output stalls, with stretches of none
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b1;
    else if ($urandom_range(0, 999) < 5) sink_busy <= ~sink_busy;
    else out_ch.ready <= sink_busy ? 1'b1 : (gap_len() == 0);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int sent;
    int slen;
    int alpha;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single byte stream, extremes, repeated runs
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    for (int i = 0; i < 12; i++) send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // one long stream that spreads entries over many rows
    for (int i = 0; i < 600; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 3)), 1'b0);
    send_byte(8'h7E, 1'b1);

    // random streams, mostly from small alphabets so matches grow
    sent = 0;
    while (sent < 1050) begin
      slen = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 120);
      alpha = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 7);
      for (int i = 0; i < slen; i++)
        send_byte(8'($urandom_range(0, alpha) ^ (alpha == 255 ? 0 : 8'hC0 & $urandom)),
                  i == slen - 1);
      sent += slen;
    end
    in_ch.valid <= 1'b0;

    while (codes_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
